// File: hdl/calendar_clock_counter_defines.svh
// assertion macros for the calendar clock counter
`ifndef CALENDAR_CLOCK_COUNTER_DEFINES_SVH
`define CALENDAR_CLOCK_COUNTER_DEFINES_SVH

`ifndef SYNTHESIS
`define CCC_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ccc assertion failed");
`define CCC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ccc assertion failed");
`else
`define CCC_ASSERT_SAME(name, clk, rst, ante, cons)
`define CCC_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

// File: hdl/ccc_pkg.sv
package ccc_pkg;

   // packed so that second sits in the lowest bits
   typedef struct packed {
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } ccc_time_type;

   typedef struct packed {
      logic [15:0] ticks_per_second;
      logic [4:0]  hour_offset;
   } ccc_cfg_type;

   localparam logic [15:0] TPS_RESET    = 16'd1000;
   localparam logic [4:0]  OFFSET_RESET = 5'd1;

   localparam logic CSR_TICKS_PER_SECOND = 1'b0;
   localparam logic CSR_HOUR_OFFSET      = 1'b1;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_LOAD = 1'b1;

   localparam logic [5:0]  LAST_SECOND = 6'd59;
   localparam logic [5:0]  LAST_MINUTE = 6'd59;
   localparam logic [4:0]  LAST_HOUR   = 5'd23;
   localparam logic [3:0]  LAST_MONTH  = 4'd12;
   localparam logic [13:0] LAST_YEAR   = 14'd9999;

   // gregorian leap rule; y/100 by reciprocal, exact for any 14-bit year
   function automatic logic is_leap(input logic [13:0] y);
      logic [27:0] prod;
      logic [7:0]  q;
      logic [13:0] qx;
      logic [13:0] hund;
      logic        div100;
      prod   = 28'(y) * 28'd5243;
      q      = prod[26:19];
      qx     = 14'(q);
      hund   = (qx << 6) + (qx << 5) + (qx << 2);
      div100 = (hund == y);
      return (div100 && (q[1:0] == 2'd0)) || (!div100 && (y[1:0] == 2'd0));
   endfunction

   function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
      logic [4:0] d;
      case (m)
         4'd1:    d = 5'd31;
         4'd2:    d = leap ? 5'd29 : 5'd28;
         4'd3:    d = 5'd31;
         4'd4:    d = 5'd30;
         4'd5:    d = 5'd31;
         4'd6:    d = 5'd30;
         4'd7:    d = 5'd31;
         4'd8:    d = 5'd31;
         4'd9:    d = 5'd30;
         4'd10:   d = 5'd31;
         4'd11:   d = 5'd30;
         4'd12:   d = 5'd31;
         default: d = 5'd31;
      endcase
      return d;
   endfunction

   // (h + o) mod 24 for a sum below 64
   function automatic logic [4:0] hour_wrap(input logic [4:0] h, input logic [4:0] o);
      logic [5:0] s;
      s = {1'b0, h} + {1'b0, o};
      if (s >= 6'd48) begin
         s = s - 6'd48;
      end else if (s >= 6'd24) begin
         s = s - 6'd24;
      end
      return s[4:0];
   endfunction

endpackage

// File: hdl/ccc_clock_core.sv
module ccc_clock_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic                  op,
   input  ccc_pkg::ccc_time_type load,
   input  ccc_pkg::ccc_cfg_type  cfg,
   output ccc_pkg::ccc_time_type time_next,
   output logic                  resync
);
   import ccc_pkg::*;

   logic [15:0]  tick_ff, tick_in;
   ccc_time_type time_ff, time_in;
   logic         leap_ff, leap_in;

   logic [16:0]  tick_sum;
   logic         sec_pulse;
   logic [13:0]  year_next;
   logic         leap_next;

   assign tick_sum  = {1'b0, tick_ff} + 17'd1;
   assign sec_pulse = (op == OP_TICK) && (tick_sum >= {1'b0, cfg.ticks_per_second});

   // next year and its leap status, off the carry chain
   assign year_next = (time_ff.year >= LAST_YEAR) ? 14'd0 : time_ff.year + 14'd1;
   assign leap_next = is_leap(year_next);

   always_comb begin
      time_in = time_ff;
      leap_in = leap_ff;
      tick_in = tick_ff;
      resync  = 1'b0;
      if (op == OP_LOAD) begin
         time_in      = load;
         time_in.hour = hour_wrap(load.hour, cfg.hour_offset);
         leap_in      = is_leap(load.year);
      end else if (!sec_pulse) begin
         tick_in = tick_sum[15:0];
      end else begin
         tick_in = 16'd0;
         if (time_ff.second < LAST_SECOND) begin
            time_in.second = time_ff.second + 6'd1;
         end else begin
            time_in.second = 6'd0;
            if (time_ff.minute < LAST_MINUTE) begin
               time_in.minute = time_ff.minute + 6'd1;
            end else begin
               time_in.minute = 6'd0;
               resync         = 1'b1;
               if (time_ff.hour < LAST_HOUR) begin
                  time_in.hour = time_ff.hour + 5'd1;
               end else begin
                  time_in.hour = 5'd0;
                  if (time_ff.day < days_in(time_ff.month, leap_ff)) begin
                     time_in.day = time_ff.day + 5'd1;
                  end else begin
                     time_in.day = 5'd1;
                     if (time_ff.month < LAST_MONTH) begin
                        time_in.month = time_ff.month + 4'd1;
                     end else begin
                        time_in.month = 4'd1;
                        time_in.year  = year_next;
                        leap_in       = leap_next;
                     end
                  end
               end
            end
         end
      end
   end

   assign time_next = time_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff <= 16'd0;
         time_ff <= '{year: 14'd0, month: 4'd1, day: 5'd1, hour: 5'd0,
                      minute: 6'd0, second: 6'd0};
         leap_ff <= 1'b1;
      end else if (accept) begin
         tick_ff <= tick_in;
         time_ff <= time_in;
         leap_ff <= leap_in;
      end
   end

endmodule

// File: hdl/calendar_clock_counter.sv
// Real-time clock and calendar.
// req channel: one item per tick or load. req_tuser is the op (0 = millisecond
// tick, 1 = load time from reference); req_tdata carries the load fields, used
// only for a load. A load adds the configured hour offset modulo 24.
// rsp channel: exactly one item per request, the time after that request;
// rsp_tuser flags an hour rollover so the host can resync from its reference.
// csr port: index 0 ticks per second, index 1 hour offset; write only while
// the block is idle.
// rsp_tvalid rises in the cycle after a request is accepted. Throughput is one
// item per cycle while the receiver takes each result: the tick compare and
// the second-to-year carry chain are combinational before the result register.
// When the receiver stalls, the result register holds and req_tready drops
// until it is taken; a new request is accepted in the same cycle the pending
// result leaves.
// Synchronous reset sets 00:00:00, day 1, month 1, year 0, clears the tick
// count and the result valid flag, and restores 1000 ticks per second and an
// hour offset of 1.
`include "calendar_clock_counter_defines.svh"

module calendar_clock_counter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // load_second, load_minute, load_hour, load_day, load_month, load_year
   input  logic [39:0] req_tdata,
   // op
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // cur_second, cur_minute, cur_hour, cur_day, cur_month, cur_year
   output logic [39:0] rsp_tdata,
   // resync_request
   output logic        rsp_tuser,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);
   import ccc_pkg::*;

   ccc_cfg_type  cfg_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   ccc_time_type rsp_time_ff;
   logic         rsp_resync_ff;

   logic         accept;
   ccc_time_type load;
   ccc_time_type time_next;
   logic         resync;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign load       = ccc_time_type'(req_tdata);

   ccc_clock_core u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .op        (req_tuser),
      .load      (load),
      .cfg       (cfg_ff),
      .time_next (time_next),
      .resync    (resync)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ticks_per_second <= TPS_RESET;
         cfg_ff.hour_offset      <= OFFSET_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TICKS_PER_SECOND: cfg_ff.ticks_per_second <= csr_wdata;
            CSR_HOUR_OFFSET:      cfg_ff.hour_offset      <= csr_wdata[4:0];
            default:              cfg_ff                  <= cfg_ff;
         endcase
      end
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_time_ff   <= time_next;
         rsp_resync_ff <= resync;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_time_ff;
   assign rsp_tuser  = rsp_resync_ff;

   // an empty result register never blocks the request side
   `CCC_ASSERT_SAME(a_ready_when_empty, clock, reset, !rsp_valid_ff, req_tready)
   `CCC_ASSERT_NEXT(a_accept_gives_result, clock, reset, accept, rsp_valid_ff)
   // hour rollover only happens with minute and second wrapped to zero
   `CCC_ASSERT_SAME(a_resync_on_hour, clock, reset, rsp_valid_ff && rsp_resync_ff,
      (rsp_time_ff.minute == 6'd0) && (rsp_time_ff.second == 6'd0))
   `CCC_ASSERT_SAME(a_hour_in_range, clock, reset, rsp_valid_ff,
      rsp_time_ff.hour <= LAST_HOUR)

endmodule
